// ===== design/i2cseq_pkg.sv =====
// Package: codes, limits and item types for the I2C register transfer sequencer.
`timescale 1ns / 1ps

package i2cseq_pkg;

   localparam int unsigned MAX_TRANSFER_BYTES = 255;

   // transfer status codes
   localparam logic [1:0] ST_ACTIVE = 2'd0;
   localparam logic [1:0] ST_PASSED = 2'd1;
   localparam logic [1:0] ST_FAILED = 2'd2;

   // master state codes reported with a pending event
   localparam logic [2:0] MS_IDLE     = 3'd0;
   localparam logic [2:0] MS_RX_READY = 3'd1;
   localparam logic [2:0] MS_TX_READY = 3'd2;

   // item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_EVENT = 1'b1;

   typedef struct packed {
      logic       func;
      logic [6:0] slave_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic       write_mode;
      logic       arb_lost;
      logic       start_stop_error;
      logic       pending;
      logic [2:0] master_state;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic       start_rejected;
      logic       data_write_valid;
      logic [7:0] data_out;
      logic       ctl_valid;
      logic       ctl_continue;
      logic       ctl_start;
      logic       ctl_stop;
      logic       rx_store;
      logic [7:0] buffer_index;
      logic [1:0] xfer_status;
      logic       notify;
   } rsp_type;

endpackage

// ===== design/i2c_master_register_transfer_sequencer.sv =====
// Top level: I2C master register transfer sequencer with input and result registers.
`timescale 1ns / 1ps
// Path: an accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low; the transfer state is updated as an
//   item moves from the input register into the result register, so back-to-back items chain.
// Reset: synchronous, active high; status reads passed, counters and addresses clear,
//   both pipeline registers empty.

module i2c_master_register_transfer_sequencer
   import i2cseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [6:0] req_slave_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_byte_count,
   input  logic       req_write_mode,
   input  logic       req_arb_lost,
   input  logic       req_start_stop_error,
   input  logic       req_pending,
   input  logic [2:0] req_master_state,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_tx_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_start_rejected,
   output logic       rsp_data_write_valid,
   output logic [7:0] rsp_data_out,
   output logic       rsp_ctl_valid,
   output logic       rsp_ctl_continue,
   output logic       rsp_ctl_start,
   output logic       rsp_ctl_stop,
   output logic       rsp_rx_store,
   output logic [7:0] rsp_buffer_index,
   output logic [1:0] rsp_xfer_status,
   output logic       rsp_notify
);

   // input register
   logic    s1_valid_ff;
   req_type s1_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // transfer state
   logic [1:0] status_ff,   status_in;
   logic       phase_ff,    phase_in;
   logic [7:0] remain_ff,   remain_in;
   logic [7:0] pos_ff,      pos_in;
   logic [7:0] addr_ff,     addr_in;
   logic [7:0] regbyte_ff,  regbyte_in;
   logic       wmode_ff,    wmode_in;

   logic       out_free;
   logic       advance;
   logic       req_take;
   logic [7:0] remain_dec;

   // The result register frees when empty or when its item is taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   // Stall only while the input register holds an item that cannot move on.
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Saturating count-down used by receive handling.
   assign remain_dec = (remain_ff != 8'd0) ? (remain_ff - 8'd1) : 8'd0;

   // Per-item transfer logic: decide the result and the next transfer state.
   always_comb begin
      rsp_in              = '0;
      rsp_in.buffer_index = pos_ff;
      status_in           = status_ff;
      phase_in            = phase_ff;
      remain_in           = remain_ff;
      pos_in              = pos_ff;
      addr_in             = addr_ff;
      regbyte_in          = regbyte_ff;
      wmode_in            = wmode_ff;

      if (s1_ff.func == FUNC_START) begin
         if (status_ff == ST_ACTIVE) begin
            // refuse a new transfer while one is running
            rsp_in.start_rejected = 1'b1;
         end else begin
            addr_in    = {s1_ff.slave_addr, 1'b0};
            regbyte_in = s1_ff.reg_addr;
            status_in  = ST_ACTIVE;
            remain_in  = (32'(s1_ff.byte_count) > 32'(MAX_TRANSFER_BYTES)) ?
                         8'(MAX_TRANSFER_BYTES) : s1_ff.byte_count;
            pos_in     = 8'd0;
            phase_in   = 1'b0;
            wmode_in   = s1_ff.write_mode;
            // address with write bit, then START
            rsp_in.data_write_valid = 1'b1;
            rsp_in.data_out         = {s1_ff.slave_addr, 1'b0};
            rsp_in.ctl_valid        = 1'b1;
            rsp_in.ctl_start        = 1'b1;
         end
      end else if (s1_ff.arb_lost || s1_ff.start_stop_error) begin
         // bus error: fail, and release the master if it is waiting
         if (s1_ff.pending) begin
            rsp_in.ctl_valid    = 1'b1;
            rsp_in.ctl_continue = 1'b1;
         end
         status_in     = ST_FAILED;
         rsp_in.notify = 1'b1;
      end else if (s1_ff.pending) begin
         unique case (s1_ff.master_state)
            MS_IDLE: begin
               if (status_ff == ST_ACTIVE && remain_ff == 8'd0) begin
                  status_in     = ST_PASSED;
                  rsp_in.notify = 1'b1;
               end
            end
            MS_RX_READY: begin
               // store the byte, stop after the last one
               rsp_in.rx_store     = 1'b1;
               pos_in              = pos_ff + 8'd1;
               remain_in           = remain_dec;
               rsp_in.ctl_valid    = 1'b1;
               rsp_in.ctl_continue = 1'b1;
               rsp_in.ctl_stop     = (remain_dec == 8'd0);
            end
            MS_TX_READY: begin
               rsp_in.ctl_valid    = 1'b1;
               rsp_in.ctl_continue = 1'b1;
               if (!phase_ff) begin
                  // register byte goes first in both directions
                  rsp_in.data_write_valid = 1'b1;
                  rsp_in.data_out         = regbyte_ff;
                  phase_in                = 1'b1;
               end else if (wmode_ff) begin
                  if (remain_ff == 8'd0) begin
                     rsp_in.ctl_stop = 1'b1;
                  end else begin
                     rsp_in.data_write_valid = 1'b1;
                     rsp_in.data_out         = s1_ff.tx_byte;
                     pos_in                  = pos_ff + 8'd1;
                     remain_in               = remain_ff - 8'd1;
                  end
               end else begin
                  // repeated START with the read address
                  rsp_in.data_write_valid = 1'b1;
                  rsp_in.data_out         = {addr_ff[7:1], 1'b1};
                  rsp_in.ctl_start        = 1'b1;
               end
            end
            default: begin
               // address nack, data nack and unknown codes: stop and fail
               rsp_in.ctl_valid    = 1'b1;
               rsp_in.ctl_continue = 1'b1;
               rsp_in.ctl_stop     = 1'b1;
               status_in           = ST_FAILED;
               rsp_in.notify       = 1'b1;
            end
         endcase
      end

      rsp_in.xfer_status = status_in;
   end

   // Input register: load on accept, drop when the item moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= '{func:             req_func,
                    slave_addr:       req_slave_addr,
                    reg_addr:         req_reg_addr,
                    byte_count:       req_byte_count,
                    write_mode:       req_write_mode,
                    arb_lost:         req_arb_lost,
                    start_stop_error: req_start_stop_error,
                    pending:          req_pending,
                    master_state:     req_master_state,
                    rx_byte:          req_rx_byte,
                    tx_byte:          req_tx_byte};
      end
   end

   // Result register: fill on advance, empty when taken with nothing behind.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Transfer state: commit once per item as it advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= ST_PASSED;
         phase_ff   <= 1'b0;
         remain_ff  <= 8'd0;
         pos_ff     <= 8'd0;
         addr_ff    <= 8'd0;
         regbyte_ff <= 8'd0;
         wmode_ff   <= 1'b0;
      end else if (advance) begin
         status_ff  <= status_in;
         phase_ff   <= phase_in;
         remain_ff  <= remain_in;
         pos_ff     <= pos_in;
         addr_ff    <= addr_in;
         regbyte_ff <= regbyte_in;
         wmode_ff   <= wmode_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_rejected   = rsp_ff.start_rejected;
   assign rsp_data_write_valid = rsp_ff.data_write_valid;
   assign rsp_data_out         = rsp_ff.data_out;
   assign rsp_ctl_valid        = rsp_ff.ctl_valid;
   assign rsp_ctl_continue     = rsp_ff.ctl_continue;
   assign rsp_ctl_start        = rsp_ff.ctl_start;
   assign rsp_ctl_stop         = rsp_ff.ctl_stop;
   assign rsp_rx_store         = rsp_ff.rx_store;
   assign rsp_buffer_index     = rsp_ff.buffer_index;
   assign rsp_xfer_status      = rsp_ff.xfer_status;
   assign rsp_notify           = rsp_ff.notify;

`ifndef NO_ASSERTIONS
   // A refused start carries no bus activity.
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_rejected |-> !rsp_ctl_valid && !rsp_data_write_valid)
      else $error("rejected start item drives the bus");

   // Software is notified only when the transfer has finished.
   a_notify_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notify |-> rsp_xfer_status != ST_ACTIVE)
      else $error("notify with transfer still active");

   // Any START goes out together with an address byte: write bit on the first START,
   // read bit on a repeated START.
   a_start_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ctl_start |-> rsp_data_write_valid && rsp_data_out[0] == rsp_ctl_continue)
      else $error("START without matching address byte");

   // A received byte always releases the master with continue set.
   a_rx_continue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_store |-> rsp_ctl_valid && rsp_ctl_continue)
      else $error("received byte without continue");

   // The input register never stalls while empty.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("stall with room to advance");
`endif

endmodule
